### sv/assert_macros.svh
// assertion shorthands for the image scoring modules, included by isr_rank
// expects signals named clock and reset in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ISR_ASSERT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ISR_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/isr_pkg.sv
// shared types and constants for the image sum-of-squared-differences ranker
// no dependencies
package isr_pkg;

   localparam int PIXEL_W   = 8;
   localparam int SQ_W      = 2 * PIXEL_W;
   localparam int DIM_CFG_W = 11;
   localparam int CNT_CFG_W = 7;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 11;
   localparam int RANK_W    = 6;
   localparam int ERR_W     = 36;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPECIMEN_COUNT = 2'd2;

   localparam logic [DIM_CFG_W-1:0] RST_IMAGE_WIDTH    = 11'd64;
   localparam logic [DIM_CFG_W-1:0] RST_IMAGE_HEIGHT   = 11'd64;
   localparam logic [CNT_CFG_W-1:0] RST_SPECIMEN_COUNT = 7'd16;

   typedef enum logic [1:0] {
      RK_IDLE,
      RK_SCAN,
      RK_EMIT
   } isr_state_type;

   // accumulator to ranker control strobes
   typedef struct packed {
      logic score_we;
      logic round_done;
   } isr_ctl_type;

endpackage

### sv/image_ssd_rank.sv
// top level of the image sum-of-squared-differences ranker: config registers,
// geometry clamping; depends on isr_pkg, isr_accum, isr_rank
//
//   port group  dir  handshake              payload
//   req_        in   req_valid/req_ready    specimen_pixel, pattern_pixel
//   rsp_        out  rsp_valid/rsp_ready    rank_position, specimen_index,
//                                           total_error, last_of_run
//   csr_        in   csr_valid/csr_ready    index, wdata (always ready)
//
// one pixel request per cycle while streaming a round
// after the last pixel of a round the selection pass runs: for each rank place
// a scan of the stored scores, then an emit that holds until rsp_ready
// req_ready is low during ranking and in the cycle after reset or a csr write
// (pixel total and count are registered from the config values)
module image_ssd_rank
   import isr_pkg::*;
#(
   parameter int MAX_SPECIMENS = 64,
   parameter int MAX_DIMENSION = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [PIXEL_W-1:0]   req_specimen_pixel,
   input  logic [PIXEL_W-1:0]   req_pattern_pixel,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [RANK_W-1:0]    rsp_rank_position,
   output logic [RANK_W-1:0]    rsp_specimen_index,
   output logic [ERR_W-1:0]     rsp_total_error,
   output logic                 rsp_last_of_run,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
   localparam int PIX_W = $clog2(MAX_DIMENSION * MAX_DIMENSION + 1);
   localparam int IDX_W = $clog2(MAX_SPECIMENS);
   localparam int CNT_W = $clog2(MAX_SPECIMENS + 1);
   localparam int ACC_W = SQ_W + PIX_W;

   logic [DIM_CFG_W-1:0] image_width_ff, image_width_in;
   logic [DIM_CFG_W-1:0] image_height_ff, image_height_in;
   logic [CNT_CFG_W-1:0] specimen_count_ff, specimen_count_in;
   logic                 cfg_pend_ff;
   logic [PIX_W-1:0]     pixel_total_ff, pixel_total_in;
   logic [CNT_W-1:0]     spec_total_ff, spec_total_in;
   logic [DIM_W-1:0]     width_eff, height_eff;
   logic                 csr_fire;
   logic                 fire;
   logic                 rank_busy;
   isr_ctl_type          ctl;
   logic [IDX_W-1:0]     wr_addr;
   logic [ACC_W-1:0]     wr_data;
   logic [CNT_W-1:0]     round_count;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid & csr_ready;
   assign req_ready = ~cfg_pend_ff & ~rank_busy;
   assign fire      = req_valid & req_ready;

   always_comb begin
      image_width_in    = image_width_ff;
      image_height_in   = image_height_ff;
      specimen_count_in = specimen_count_ff;
      if (csr_fire) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:    image_width_in    = csr_wdata;
            CSR_IMAGE_HEIGHT:   image_height_in   = csr_wdata;
            CSR_SPECIMEN_COUNT: specimen_count_in = csr_wdata[CNT_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // saturate geometry and count to their usable ranges
   always_comb begin
      if (image_width_ff == '0) width_eff = DIM_W'(1);
      else if (32'(image_width_ff) > 32'(MAX_DIMENSION)) width_eff = DIM_W'(MAX_DIMENSION);
      else width_eff = DIM_W'(image_width_ff);

      if (image_height_ff == '0) height_eff = DIM_W'(1);
      else if (32'(image_height_ff) > 32'(MAX_DIMENSION)) height_eff = DIM_W'(MAX_DIMENSION);
      else height_eff = DIM_W'(image_height_ff);

      if (32'(specimen_count_ff) < 32'(2)) spec_total_in = CNT_W'(2);
      else if (32'(specimen_count_ff) > 32'(MAX_SPECIMENS)) spec_total_in = CNT_W'(MAX_SPECIMENS);
      else spec_total_in = CNT_W'(specimen_count_ff);

      pixel_total_in = PIX_W'(width_eff) * PIX_W'(height_eff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff    <= RST_IMAGE_WIDTH;
         image_height_ff   <= RST_IMAGE_HEIGHT;
         specimen_count_ff <= RST_SPECIMEN_COUNT;
         cfg_pend_ff       <= 1'b1;
      end else begin
         image_width_ff    <= image_width_in;
         image_height_ff   <= image_height_in;
         specimen_count_ff <= specimen_count_in;
         cfg_pend_ff       <= csr_fire;
      end
   end

   always_ff @(posedge clock) begin
      pixel_total_ff <= pixel_total_in;
      spec_total_ff  <= spec_total_in;
   end

   isr_accum #(
      .PIX_W (PIX_W),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W),
      .ACC_W (ACC_W)
   ) u_accum (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire),
      .specimen_pixel (req_specimen_pixel),
      .pattern_pixel  (req_pattern_pixel),
      .pixel_total    (pixel_total_ff),
      .specimen_total (spec_total_ff),
      .ctl            (ctl),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .round_count    (round_count)
   );

   isr_rank #(
      .MAX_SPECIMENS (MAX_SPECIMENS),
      .IDX_W         (IDX_W),
      .CNT_W         (CNT_W),
      .ACC_W         (ACC_W)
   ) u_rank (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .wr_addr            (wr_addr),
      .wr_data            (wr_data),
      .round_count        (round_count),
      .busy               (rank_busy),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_rank_position  (rsp_rank_position),
      .rsp_specimen_index (rsp_specimen_index),
      .rsp_total_error    (rsp_total_error),
      .rsp_last_of_run    (rsp_last_of_run)
   );

endmodule

### sv/isr_accum.sv
// per-pixel squared difference and running sum, specimen and round counting
// depends on isr_pkg
module isr_accum
   import isr_pkg::*;
#(
   parameter int PIX_W = 21,
   parameter int IDX_W = 6,
   parameter int CNT_W = 7,
   parameter int ACC_W = 37
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  logic [PIXEL_W-1:0] specimen_pixel,
   input  logic [PIXEL_W-1:0] pattern_pixel,
   input  logic [PIX_W-1:0]   pixel_total,
   input  logic [CNT_W-1:0]   specimen_total,
   output isr_ctl_type        ctl,
   output logic [IDX_W-1:0]   wr_addr,
   output logic [ACC_W-1:0]   wr_data,
   output logic [CNT_W-1:0]   round_count
);

   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [PIX_W-1:0]   pix_ff, pix_in;
   logic [IDX_W-1:0]   spec_ff, spec_in;
   logic [PIXEL_W-1:0] diff;
   logic [SQ_W-1:0]    sq;
   logic [ACC_W-1:0]   sum;
   logic [PIX_W:0]     pix_inc;
   logic [CNT_W-1:0]   spec_inc;

   always_comb begin
      diff     = (specimen_pixel >= pattern_pixel) ? (specimen_pixel - pattern_pixel)
                                                   : (pattern_pixel - specimen_pixel);
      sq       = SQ_W'(diff) * SQ_W'(diff);
      sum      = acc_ff + ACC_W'(sq);
      pix_inc  = {1'b0, pix_ff} + (PIX_W+1)'(1);
      spec_inc = CNT_W'(spec_ff) + CNT_W'(1);
   end

   always_comb begin
      acc_in         = acc_ff;
      pix_in         = pix_ff;
      spec_in        = spec_ff;
      ctl.score_we   = 1'b0;
      ctl.round_done = 1'b0;
      if (fire) begin
         if (pix_inc < {1'b0, pixel_total}) begin
            acc_in = sum;
            pix_in = pix_inc[PIX_W-1:0];
         end else begin
            // specimen complete
            acc_in       = '0;
            pix_in       = '0;
            ctl.score_we = 1'b1;
            if (spec_inc < specimen_total) begin
               spec_in = spec_inc[IDX_W-1:0];
            end else begin
               spec_in        = '0;
               ctl.round_done = 1'b1;
            end
         end
      end
   end

   assign wr_addr     = spec_ff;
   assign wr_data     = sum;
   assign round_count = spec_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         pix_ff  <= '0;
         spec_ff <= '0;
      end else begin
         acc_ff  <= acc_in;
         pix_ff  <= pix_in;
         spec_ff <= spec_in;
      end
   end

endmodule

### sv/isr_rank.sv
// score memory and selection sequencer: two key comparators check the
// stored scores once per rank place; depends on isr_pkg and assert_macros.svh
`include "assert_macros.svh"
module isr_rank
   import isr_pkg::*;
#(
   parameter int MAX_SPECIMENS = 64,
   parameter int IDX_W = 6,
   parameter int CNT_W = 7,
   parameter int ACC_W = 37
) (
   input  logic              clock,
   input  logic              reset,
   input  isr_ctl_type       ctl,
   input  logic [IDX_W-1:0]  wr_addr,
   input  logic [ACC_W-1:0]  wr_data,
   input  logic [CNT_W-1:0]  round_count,
   output logic              busy,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [RANK_W-1:0] rsp_rank_position,
   output logic [RANK_W-1:0] rsp_specimen_index,
   output logic [ERR_W-1:0]  rsp_total_error,
   output logic              rsp_last_of_run
);

   localparam int KEY_W = ACC_W + IDX_W;

   logic [ACC_W-1:0] score_mem [MAX_SPECIMENS];

   isr_state_type    state_ff, state_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [IDX_W-1:0] cmp_ptr_ff, cmp_ptr_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [ACC_W-1:0] rd_data_ff;
   logic [KEY_W-1:0] best_key_ff, best_key_in;
   logic             best_vld_ff, best_vld_in;
   logic [KEY_W-1:0] prev_key_ff, prev_key_in;
   logic             has_prev_ff, has_prev_in;
   logic             rd_en;
   logic [KEY_W-1:0] cand;
   logic             take;
   logic             scan_done;
   logic             last;

   // key is score then index, so equal scores order by index
   always_comb begin
      cand      = {rd_data_ff, cmp_ptr_ff};
      take      = cmp_vld_ff && (!has_prev_ff || cand > prev_key_ff)
                             && (!best_vld_ff || cand < best_key_ff);
      scan_done = (rd_ptr_ff == n_ff) && !cmp_vld_ff;
      last      = (CNT_W'(k_ff) + CNT_W'(1)) == n_ff;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         RK_IDLE: begin
            if (ctl.round_done) state_in = RK_SCAN;
         end
         RK_SCAN: begin
            if (scan_done) state_in = RK_EMIT;
         end
         RK_EMIT: begin
            if (rsp_ready) state_in = last ? RK_IDLE : RK_SCAN;
         end
         default: state_in = RK_IDLE;
      endcase
   end

   always_comb begin
      n_in        = n_ff;
      k_in        = k_ff;
      rd_ptr_in   = rd_ptr_ff;
      cmp_ptr_in  = cmp_ptr_ff;
      cmp_vld_in  = 1'b0;
      best_key_in = best_key_ff;
      best_vld_in = best_vld_ff;
      prev_key_in = prev_key_ff;
      has_prev_in = has_prev_ff;
      rd_en       = 1'b0;
      case (state_ff)
         RK_IDLE: begin
            if (ctl.round_done) begin
               n_in        = round_count;
               k_in        = '0;
               rd_ptr_in   = '0;
               best_vld_in = 1'b0;
               has_prev_in = 1'b0;
            end
         end
         RK_SCAN: begin
            if (rd_ptr_ff < n_ff) begin
               rd_en      = 1'b1;
               rd_ptr_in  = rd_ptr_ff + CNT_W'(1);
               cmp_vld_in = 1'b1;
               cmp_ptr_in = rd_ptr_ff[IDX_W-1:0];
            end
            if (take) begin
               best_key_in = cand;
               best_vld_in = 1'b1;
            end
         end
         RK_EMIT: begin
            if (rsp_ready) begin
               // next place: smallest key above the one just sent
               prev_key_in = best_key_ff;
               has_prev_in = 1'b1;
               best_vld_in = 1'b0;
               rd_ptr_in   = '0;
               k_in        = k_ff + IDX_W'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.score_we) score_mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= score_mem[rd_ptr_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= RK_IDLE;
         cmp_vld_ff  <= 1'b0;
         best_vld_ff <= 1'b0;
         has_prev_ff <= 1'b0;
         n_ff        <= '0;
         k_ff        <= '0;
         rd_ptr_ff   <= '0;
      end else begin
         state_ff    <= state_in;
         cmp_vld_ff  <= cmp_vld_in;
         best_vld_ff <= best_vld_in;
         has_prev_ff <= has_prev_in;
         n_ff        <= n_in;
         k_ff        <= k_in;
         rd_ptr_ff   <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_ptr_ff  <= cmp_ptr_in;
      best_key_ff <= best_key_in;
      prev_key_ff <= prev_key_in;
   end

   assign busy               = (state_ff != RK_IDLE);
   assign rsp_valid          = (state_ff == RK_EMIT);
   assign rsp_rank_position  = RANK_W'(k_ff);
   assign rsp_specimen_index = RANK_W'(best_key_ff[IDX_W-1:0]);
   assign rsp_total_error    = ERR_W'(best_key_ff[KEY_W-1:IDX_W]);
   assign rsp_last_of_run    = last;

   `ISR_ASSERT(a_write_only_idle, ctl.score_we, state_ff == RK_IDLE,
               "score write while ranking")
   `ISR_ASSERT(a_emit_has_best, state_ff == RK_EMIT, best_vld_ff,
               "emitting with no selected specimen")
   `ISR_ASSERT(a_ptr_in_range, state_ff == RK_SCAN, rd_ptr_ff <= n_ff,
               "read pointer past specimen count")
   `ISR_ASSERT_NEXT(a_next_place, state_ff == RK_EMIT && rsp_ready && !last,
                    state_ff == RK_SCAN && k_ff == $past(k_ff) + IDX_W'(1),
                    "rank place did not advance")

endmodule
